// ===== rtl/hourly_histogram_top_k_assert.svh =====
// ----------------------------------------------------------------------------
// hourly_histogram_top_k_assert
// assertion macros for the histogram block
// ----------------------------------------------------------------------------
`ifndef HOURLY_HISTOGRAM_TOP_K_ASSERT_SVH
`define HOURLY_HISTOGRAM_TOP_K_ASSERT_SVH

// check a condition at every edge outside reset
`define HHTK_ASSERT_NOW(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("hhtk assertion failed");

// check that a condition implies another at the next edge
`define HHTK_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("hhtk assertion failed");

`endif

// ===== rtl/hhtk_pkg.sv =====
// ----------------------------------------------------------------------------
// hhtk_pkg
// types and constants shared by the time histogram files
// ----------------------------------------------------------------------------
package hhtk_pkg;

    localparam int MAX_BUCKETS = 16384;
    localparam int ADDR_W      = $clog2(MAX_BUCKETS);
    localparam int NB_W        = ADDR_W + 1;
    localparam int MAX_RESULTS = 64;
    localparam int K_W         = 7;
    localparam int CFG_IDX_W   = 8;

    localparam logic [31:0]   RST_BASE_TIME      = 32'd1645491600;
    localparam logic [15:0]   RST_BUCKET_SECONDS = 16'd3600;
    localparam logic [14:0]   RST_BUCKET_COUNT   = 15'd9312;
    localparam logic [K_W-1:0] RST_TOP_K         = 7'd5;

    localparam logic [CFG_IDX_W-1:0] REG_BASE_TIME      = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BUCKET_SECONDS = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BUCKET_COUNT   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_K          = 8'd3;

    localparam logic MODE_COUNT  = 1'b0;
    localparam logic MODE_REPORT = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [31:0] timestamp;
    } in_t;

    typedef struct packed {
        logic [31:0] bucket_start;
        logic [31:0] hits;
        logic        last;
    } out_t;

    typedef struct packed {
        logic              done;
        logic [ADDR_W-1:0] quotient;
    } div_stat_t;

endpackage

// ===== rtl/hhtk_div.sv =====
// ----------------------------------------------------------------------------
// hhtk_div
// restoring divider, one quotient bit per cycle, quotient known to fit ADDR_W
// ----------------------------------------------------------------------------
module hhtk_div import hhtk_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [15:0] divisor,
    output div_stat_t   stat
);

    logic [15:0]       rem_reg;
    logic [31:0]       num_reg;
    logic [15:0]       den_reg;
    logic [ADDR_W-1:0] q_reg;
    logic [NB_W-1:0]   cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [16:0]       trial;

    assign trial = {rem_reg, num_reg[31]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= 16'(dividend[31:ADDR_W]);
                num_reg  <= {dividend[ADDR_W-1:0], {(32-ADDR_W){1'b0}}};
                den_reg  <= divisor;
            end else if (busy_reg) begin
                num_reg <= {num_reg[30:0], 1'b0};
                if (trial >= {1'b0, den_reg}) begin
                    rem_reg <= 16'(trial - {1'b0, den_reg});
                    q_reg   <= {q_reg[ADDR_W-2:0], 1'b1};
                end else begin
                    rem_reg <= trial[15:0];
                    q_reg   <= {q_reg[ADDR_W-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == NB_W'(ADDR_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign stat.done     = done_reg;
    assign stat.quotient = q_reg;

endmodule

// ===== rtl/hourly_histogram_top_k.sv =====
// ----------------------------------------------------------------------------
// hourly_histogram_top_k
// time bucket histogram in one memory with a top-k report walk
// ----------------------------------------------------------------------------
// channel  dir  payload          accepted when
// s_       in   in_t             s_valid && s_ready
// m_       out  out_t            m_valid && m_ready
// cfg_     in   index, data      cfg_valid && cfg_ready (always ready)
//
// count item in range: accept, range check, 14-step divider, read, write
// count item out of range: accept, range check
// report item: accept, then per result a scan over nb buckets and an emit, one memory read a cycle
// reset runs a clearing pass over all 16384 buckets with s_ready low
// the output register holds a result while m_ready is low; the walk waits on it
// ----------------------------------------------------------------------------
`include "hourly_histogram_top_k_assert.svh"

module hourly_histogram_top_k import hhtk_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_t                  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_t                 m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    typedef enum logic [7:0] {
        ST_CLEAR  = 8'b0000_0001,
        ST_IDLE   = 8'b0000_0010,
        ST_CCHK   = 8'b0000_0100,
        ST_CDIV   = 8'b0000_1000,
        ST_CREAD  = 8'b0001_0000,
        ST_CWRITE = 8'b0010_0000,
        ST_SCAN   = 8'b0100_0000,
        ST_EMIT   = 8'b1000_0000
    } state_t;

    state_t state_reg;

    logic [31:0] base_reg;
    logic [15:0] bsec_reg;
    logic [14:0] bcnt_reg;
    logic [K_W-1:0] topk_reg;

    logic [31:0] mem [MAX_BUCKETS];
    logic              mem_we;
    logic [ADDR_W-1:0] mem_addr;
    logic [31:0]       mem_wd;
    logic [31:0]       rd_q;

    logic [NB_W-1:0] nb;
    logic [K_W-1:0]  k_lim;
    logic [NB_W-1:0] cnt_reg;
    logic [31:0]     diff_reg;
    logic            pre_ok_reg;
    logic [30:0]     prod_reg;
    logic            div_start;
    div_stat_t       div_stat;
    logic [K_W-1:0]  k_reg;
    logic [K_W-1:0]  pass_reg;
    logic            cand_v_reg;
    logic [ADDR_W-1:0] cand_i_reg;
    logic            found_reg;
    logic [31:0]     best_h_reg;
    logic [ADDR_W-1:0] best_i_reg;
    logic [31:0]     prev_h_reg;
    logic [ADDR_W-1:0] prev_i_reg;
    logic            eligible;
    logic            better;
    logic            out_free;
    logic            emit_fire;
    logic            m_valid_reg;
    out_t            m_data_reg;

    assign nb = (bcnt_reg > 15'(MAX_BUCKETS)) ? NB_W'(MAX_BUCKETS) : NB_W'(bcnt_reg);

    always_comb begin
        k_lim = (topk_reg > K_W'(MAX_RESULTS)) ? K_W'(MAX_RESULTS) : topk_reg;
        if (NB_W'(k_lim) > nb) begin
            k_lim = K_W'(nb);
        end
    end

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= RST_BASE_TIME;
            bsec_reg <= RST_BUCKET_SECONDS;
            bcnt_reg <= RST_BUCKET_COUNT;
            topk_reg <= RST_TOP_K;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_BASE_TIME:      base_reg <= cfg_data;
                REG_BUCKET_SECONDS: bsec_reg <= cfg_data[15:0];
                REG_BUCKET_COUNT:   bcnt_reg <= cfg_data[14:0];
                REG_TOP_K:          topk_reg <= cfg_data[K_W-1:0];
                default: ;
            endcase
        end
    end

    hhtk_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (diff_reg),
        .divisor  (bsec_reg),
        .stat     (div_stat)
    );

    assign div_start = (state_reg == ST_CCHK) && pre_ok_reg && ({1'b0, prod_reg} > diff_reg);

    always_comb begin
        mem_we   = 1'b0;
        mem_addr = cnt_reg[ADDR_W-1:0];
        mem_wd   = '0;
        case (state_reg)
            ST_CLEAR: begin
                mem_we = 1'b1;
            end
            ST_CREAD, ST_CWRITE: begin
                mem_addr = div_stat.quotient;
                mem_we   = (state_reg == ST_CWRITE) && (rd_q != 32'hFFFF_FFFF);
                mem_wd   = rd_q + 32'd1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wd;
        end
        rd_q <= mem[mem_addr];
    end

    assign eligible = (pass_reg == '0) || (prev_h_reg > rd_q) ||
                      ((prev_h_reg == rd_q) && (prev_i_reg > cand_i_reg));
    assign better   = !found_reg || (rd_q > best_h_reg) ||
                      ((rd_q == best_h_reg) && (cand_i_reg > best_i_reg));
    assign out_free  = !m_valid_reg || m_ready;
    assign emit_fire = (state_reg == ST_EMIT) && out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            cnt_reg     <= '0;
            cand_v_reg  <= 1'b0;
            found_reg   <= 1'b0;
            pass_reg    <= '0;
            k_reg       <= '0;
        end else begin
            case (state_reg)
                ST_CLEAR: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == NB_W'(MAX_BUCKETS - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_valid) begin
                        if (s_data.mode == MODE_COUNT) begin
                            diff_reg   <= s_data.timestamp - base_reg;
                            pre_ok_reg <= (s_data.timestamp >= base_reg) &&
                                          (bsec_reg != '0) && (nb != '0);
                            prod_reg   <= 31'(nb * bsec_reg);
                            state_reg  <= ST_CCHK;
                        end else begin
                            k_reg      <= k_lim;
                            pass_reg   <= '0;
                            cnt_reg    <= '0;
                            found_reg  <= 1'b0;
                            cand_v_reg <= 1'b0;
                            if (k_lim != '0) begin
                                state_reg <= ST_SCAN;
                            end
                        end
                    end
                end
                ST_CCHK: begin
                    state_reg <= div_start ? ST_CDIV : ST_IDLE;
                end
                ST_CDIV: begin
                    if (div_stat.done) begin
                        state_reg <= ST_CREAD;
                    end
                end
                ST_CREAD: begin
                    state_reg <= ST_CWRITE;
                end
                ST_CWRITE: begin
                    state_reg <= ST_IDLE;
                end
                ST_SCAN: begin
                    cand_v_reg <= (cnt_reg < nb);
                    cand_i_reg <= cnt_reg[ADDR_W-1:0];
                    if (cnt_reg < nb) begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                    if (cand_v_reg && eligible && better) begin
                        found_reg  <= 1'b1;
                        best_h_reg <= rd_q;
                        best_i_reg <= cand_i_reg;
                    end
                    if ((cnt_reg == nb) && !cand_v_reg) begin
                        prod_reg  <= 31'(best_i_reg * bsec_reg);
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (emit_fire) begin
                        m_data_reg.bucket_start <= base_reg + {1'b0, prod_reg};
                        m_data_reg.hits         <= best_h_reg;
                        m_data_reg.last         <= (pass_reg + 1'b1 == k_reg);
                        prev_h_reg              <= best_h_reg;
                        prev_i_reg              <= best_i_reg;
                        pass_reg                <= pass_reg + 1'b1;
                        found_reg               <= 1'b0;
                        cnt_reg                 <= '0;
                        state_reg <= (pass_reg + 1'b1 == k_reg) ? ST_IDLE : ST_SCAN;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `HHTK_ASSERT_NOW(a_count_in_range, aclk, aresetn, (state_reg != ST_CREAD) || (NB_W'(div_stat.quotient) < nb))
    `HHTK_ASSERT_NOW(a_no_wrap, aclk, aresetn, !(mem_we && (state_reg == ST_CWRITE)) || (mem_wd != '0))
    `HHTK_ASSERT_NOW(a_pass_bound, aclk, aresetn, (state_reg != ST_SCAN) || (pass_reg < k_reg))
    `HHTK_ASSERT_NEXT(a_emit_found, aclk, aresetn, (state_reg == ST_SCAN) && (cnt_reg == nb) && !cand_v_reg, found_reg)

endmodule
